// ===== rtl/rubd_pkg.sv =====
// Shared types, constants and the per-pixel demosaic function for the RAW12 Bayer demosaic.
`default_nettype none
package rubd_pkg;

    localparam int CFG_WIDTH = 13;
    localparam int Q_DEPTH   = 4;
    localparam int QPW       = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        REG_CFA_PATTERN   = 2'd0,
        REG_PAIRS_PER_ROW = 2'd1,
        REG_ROW_COUNT     = 2'd2
    } reg_index_t;

    localparam logic [1:0]  CFA_RESET   = 2'd0;
    localparam logic [11:0] PAIRS_RESET = 12'd2048;
    localparam logic [12:0] ROWS_RESET  = 13'd3072;

    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    // Colour of each site, indexed by pattern and then {row odd, column odd}.
    localparam logic [1:0] CFA_COLOUR [4][4] = '{
        '{COL_BLUE,  COL_GREEN, COL_GREEN, COL_RED},
        '{COL_RED,   COL_GREEN, COL_GREEN, COL_BLUE},
        '{COL_GREEN, COL_RED,   COL_BLUE,  COL_GREEN},
        '{COL_GREEN, COL_BLUE,  COL_RED,   COL_GREEN}
    };

    typedef struct packed {
        logic       opcode;
        logic [7:0] packed_byte_first;
        logic [7:0] packed_byte_middle;
        logic [7:0] packed_byte_last;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
        logic       end_of_frame;
    } rgb_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One classified column pair handed from the front to the back.
    // Column element 0 is the top row, 2 the newest (bottom) row.
    typedef struct packed {
        logic            emit;
        logic            y_odd;
        logic            q_first;
        logic            top_edge;
        logic            bottom_edge;
        logic            p_nonzero;
        logic            eof;
        logic [2:0][7:0] col_a;
        logic [2:0][7:0] col_b;
    } entry_t;

    function automatic rgb_t demosaic(
        input logic [1:0] pat,
        input logic       y_odd,
        input logic       x_odd,
        input logic [7:0] ctr,
        input logic [7:0] n,
        input logic [7:0] s,
        input logic [7:0] w,
        input logic [7:0] e,
        input logic [7:0] nw,
        input logic [7:0] ne,
        input logic [7:0] sw,
        input logic [7:0] se
    );
        rgb_t       res;
        logic [1:0] c;
        logic [1:0] hc;
        logic [9:0] cross_sum;
        logic [9:0] diag;
        logic [8:0] hsum;
        logic [8:0] vsum;
        c         = CFA_COLOUR[pat][{y_odd, x_odd}];
        hc        = CFA_COLOUR[pat][{y_odd, ~x_odd}];
        cross_sum = 10'(n) + 10'(s) + 10'(w) + 10'(e);
        diag      = 10'(nw) + 10'(ne) + 10'(sw) + 10'(se);
        hsum      = 9'(w) + 9'(e);
        vsum      = 9'(n) + 9'(s);
        if (c != COL_GREEN)
        begin
            res.green = cross_sum[9:2];
            if (c == COL_RED)
            begin
                res.red  = ctr;
                res.blue = diag[9:2];
            end
            else
            begin
                res.blue = ctr;
                res.red  = diag[9:2];
            end
        end
        else
        begin
            res.green = ctr;
            if (hc == COL_RED)
            begin
                res.red  = hsum[8:1];
                res.blue = vsum[8:1];
            end
            else
            begin
                res.blue = hsum[8:1];
                res.red  = vsum[8:1];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rubd_queue.sv =====
// Short FIFO of classified entries between the front and the back.
`default_nettype none
module rubd_queue
    import rubd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire entry_t       push_data,
    input  wire logic         pop,
    output entry_t            head,
    output logic              head_valid,
    output logic [QPW:0]      count
);

    entry_t           store [Q_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW:0]     count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head       = store[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule
`default_nettype wire

// ===== rtl/rubd_front.sv =====
// Front end: position tracking, RAW12 unpacking, line stores and classification.
`default_nettype none
module rubd_front
    import rubd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_ROWS        = 4096
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pix_valid,
    output logic               pix_stall,
    input  wire pix_item_t     pix,
    input  wire logic [11:0]   pairs_per_row,
    input  wire logic [12:0]   row_count,
    input  wire logic          restart,
    input  wire logic [QPW:0]  q_count,
    output logic               push,
    output entry_t             push_data
);

    localparam int PAIRS = MAX_LINE_PIXELS / 2;
    localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 2);

    logic [15:0]   upper_mem  [PAIRS];
    logic [15:0]   middle_mem [PAIRS];
    logic [15:0]   upper_q_reg;
    logic [15:0]   middle_q_reg;

    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] col_next;
    logic [RW-1:0] row_next;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    s1_a_reg;
    logic [7:0]    s1_b_reg;
    logic          s1_fwd_reg;
    logic [15:0]   s1_fwd_upper_reg;
    logic [15:0]   s1_fwd_middle_reg;
    entry_t        s1_flags_reg;

    logic          accept;
    logic [31:0]   p_eff;
    logic [31:0]   h_eff;
    logic [31:0]   p;
    logic [31:0]   r;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [AW-1:0] addr;
    entry_t        flags;
    logic [15:0]   up_res;
    logic [15:0]   mid_res;
    logic [QPW+1:0] occupancy;

    assign occupancy = (QPW+2)'(q_count) + (QPW+2)'(s1_valid_reg);
    assign pix_stall = (occupancy >= (QPW+2)'(Q_DEPTH));
    assign accept    = pix_valid && !pix_stall;

    always_comb
    begin
        p_eff = 32'(pairs_per_row);
        if (p_eff < 32'd1)
        begin
            p_eff = 32'd1;
        end
        if (p_eff > 32'(PAIRS))
        begin
            p_eff = 32'(PAIRS);
        end
        h_eff = 32'(row_count);
        if (h_eff < 32'd2)
        begin
            h_eff = 32'd2;
        end
        if (h_eff > 32'(MAX_ROWS))
        begin
            h_eff = 32'(MAX_ROWS);
        end

        p = 32'(col_reg);
        r = 32'(row_reg);
        if (p >= p_eff || r > h_eff + 32'd1)
        begin
            p = '0;
            r = '0;
        end

        if (r < h_eff)
        begin
            a = pix.packed_byte_first;
            b = {pix.packed_byte_middle[3:0], pix.packed_byte_last[7:4]};
        end
        else
        begin
            a = '0;
            b = '0;
        end
        addr = AW'(p);

        flags             = '0;
        flags.p_nonzero   = (p != 32'd0);
        if (p != 32'd0)
        begin
            flags.emit        = (r != 32'd0);
            flags.y_odd       = ~r[0];
            flags.q_first     = (p == 32'd1);
            flags.top_edge    = (r == 32'd1);
            flags.bottom_edge = (r == h_eff);
            flags.eof         = 1'b0;
        end
        else
        begin
            flags.emit        = (r >= 32'd2);
            flags.y_odd       = r[0];
            flags.q_first     = (p_eff == 32'd1);
            flags.top_edge    = (r == 32'd2);
            flags.bottom_edge = (r == h_eff + 32'd1);
            flags.eof         = (r == h_eff + 32'd1);
        end

        if (r == h_eff + 32'd1)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (p + 32'd1 >= p_eff)
        begin
            col_next = '0;
            row_next = RW'(r + 32'd1);
        end
        else
        begin
            col_next = AW'(p + 32'd1);
            row_next = RW'(r);
        end
    end

    // Stage one resolves the store read, forwarding a write to the same pair
    // made by the item just before.
    assign up_res  = s1_fwd_reg ? s1_fwd_upper_reg  : upper_q_reg;
    assign mid_res = s1_fwd_reg ? s1_fwd_middle_reg : middle_q_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_q_reg       <= upper_mem[addr];
            middle_q_reg      <= middle_mem[addr];
            s1_addr_reg       <= addr;
            s1_a_reg          <= a;
            s1_b_reg          <= b;
            s1_flags_reg      <= flags;
            s1_fwd_reg        <= s1_valid_reg && (s1_addr_reg == addr);
            s1_fwd_upper_reg  <= mid_res;
            s1_fwd_middle_reg <= {s1_b_reg, s1_a_reg};
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_res;
            middle_mem[s1_addr_reg] <= {s1_b_reg, s1_a_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_comb
    begin
        push_data       = s1_flags_reg;
        push_data.col_a = {s1_a_reg, mid_res[7:0], up_res[7:0]};
        push_data.col_b = {s1_b_reg, mid_res[15:8], up_res[15:8]};
    end
    assign push = s1_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/rubd_back.sv =====
// Back end: 3x3 window with edge mirroring, bilinear demosaic and output register.
`default_nettype none
module rubd_back
    import rubd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  cfa_pattern,
    input  wire entry_t      head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             rgb_valid,
    input  wire logic        rgb_stall,
    output rgb_item_t        rgb
);

    logic [2:0][7:0] win_reg [3];
    logic [7:0]      w [3][4];
    rgb_item_t       rgb_reg;
    rgb_item_t       rgb_next;
    logic            valid_reg;
    rgb_t            left;
    rgb_t            right;

    assign pop = head_valid && (!valid_reg || !rgb_stall);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w[i][0] = win_reg[0][i];
            w[i][1] = win_reg[1][i];
            w[i][2] = win_reg[2][i];
            w[i][3] = head.p_nonzero ? head.col_a[i] : win_reg[1][i];
            if (head.q_first)
            begin
                w[i][0] = w[i][2];
            end
        end
        if (head.top_edge)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w[0][j] = w[2][j];
            end
        end
        if (head.bottom_edge)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w[2][j] = w[0][j];
            end
        end
        left  = demosaic(cfa_pattern, head.y_odd, 1'b0, w[1][1], w[0][1], w[2][1],
                         w[1][0], w[1][2], w[0][0], w[0][2], w[2][0], w[2][2]);
        right = demosaic(cfa_pattern, head.y_odd, 1'b1, w[1][2], w[0][2], w[2][2],
                         w[1][1], w[1][3], w[0][1], w[0][3], w[2][1], w[2][3]);
        rgb_next.red_a        = left.red;
        rgb_next.green_a      = left.green;
        rgb_next.blue_a       = left.blue;
        rgb_next.red_b        = right.red;
        rgb_next.green_b      = right.green;
        rgb_next.blue_b       = right.blue;
        rgb_next.end_of_frame = head.eof;
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.emit)
        begin
            rgb_reg <= rgb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (pop && head.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!rgb_stall)
            begin
                valid_reg <= 1'b0;
            end
            if (pop)
            begin
                win_reg[0] <= win_reg[2];
                win_reg[1] <= head.col_a;
                win_reg[2] <= head.col_b;
            end
        end
    end

    assign rgb_valid = valid_reg;
    assign rgb       = rgb_reg;

endmodule
`default_nettype wire

// ===== rtl/raw12_unpack_bayer_demosaic_top.sv =====
// Top level of the RAW12 unpack and bilinear Bayer demosaic block.
// The block takes one packed RAW12 pair per clock and gives one RGB pair per
// clock when the output side does not stall. Each pair passes through the
// front end (an issue step for the line-store read, then a resolve stage that
// also writes back), a four-entry queue, and the back end's output register.
// Results lag the input by one row plus one pair; after the last pixel pair
// of a frame, pairs_per_row + 1 flush items drain it. The single read and
// write port of each line store is used once per item and sets the rate of
// one item per cycle while the input does not stall. The input stalls only
// while the queue, counting the pair held in the front end's resolve stage,
// holds four entries. Writing pairs_per_row or row_count restarts the frame.
`default_nettype none
module raw12_unpack_bayer_demosaic_top
    import rubd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_ROWS        = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    output logic                       pix_stall,
    input  wire pix_item_t             pix,
    output logic                       rgb_valid,
    input  wire logic                  rgb_stall,
    output rgb_item_t                  rgb,
    input  wire logic                  cfg_write_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  cfg_data
);

    logic [1:0]   cfa_reg;
    logic [11:0]  pairs_reg;
    logic [12:0]  rows_reg;
    logic         restart;
    logic         push;
    entry_t       push_data;
    logic         pop;
    entry_t       head;
    logic         head_valid;
    logic [QPW:0] q_count;

    assign restart = cfg_write_en &&
                     (reg_index_t'(cfg_index) == REG_PAIRS_PER_ROW ||
                      reg_index_t'(cfg_index) == REG_ROW_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfa_reg   <= CFA_RESET;
            pairs_reg <= PAIRS_RESET;
            rows_reg  <= ROWS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_CFA_PATTERN:   cfa_reg   <= cfg_data[1:0];
                REG_PAIRS_PER_ROW: pairs_reg <= cfg_data[11:0];
                REG_ROW_COUNT:     rows_reg  <= cfg_data[12:0];
                default:           ;
            endcase
        end
    end

    rubd_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_ROWS        (MAX_ROWS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pix           (pix),
        .pairs_per_row (pairs_reg),
        .row_count     (rows_reg),
        .restart       (restart),
        .q_count       (q_count),
        .push          (push),
        .push_data     (push_data)
    );

    rubd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (q_count)
    );

    rubd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfa_pattern (cfa_reg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb         (rgb)
    );

endmodule
`default_nettype wire
